// File: design/midi_note_chord_tracker_defines.svh
// assertion macros for the chord tracker
`ifndef MIDI_NOTE_CHORD_TRACKER_DEFINES_SVH
`define MIDI_NOTE_CHORD_TRACKER_DEFINES_SVH

`ifndef ASSERT_OFF
`define MNTC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mntc assertion failed");
`define MNTC_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("mntc forbidden condition");
`else
`define MNTC_ASSERT(lbl, clk, rst_n, prop)
`define MNTC_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

// File: design/mntc_pkg.sv
`timescale 1ns / 1ps
package mntc_pkg;

  localparam int NOTE_COUNT     = 128;
  localparam int CHANNEL_COUNT  = 16;
  localparam int ADDR_W         = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1;
  localparam int SCAN_W         = ADDR_W + 1;
  localparam int PC_COUNT       = 12;
  localparam int TEMPLATE_COUNT = 18;

  localparam logic [1:0] KIND_OFF = 2'd0;
  localparam logic [1:0] KIND_ON  = 2'd1;

  localparam logic [1:0] REG_MONITOR = 2'd0;
  localparam logic [1:0] REG_LISTEN  = 2'd1;
  localparam logic [1:0] REG_LOWEST  = 2'd2;
  localparam logic [1:0] REG_HIGHEST = 2'd3;

  localparam logic [11:0] TEMPLATES [TEMPLATE_COUNT] = '{
    12'h895, 12'h495, 12'h48D, 12'h891, 12'h489, 12'h491, 12'h4A1, 12'h449, 12'h249,
    12'h291, 12'h289, 12'h091, 12'h089, 12'h049, 12'h111, 12'h085, 12'h0A1, 12'h095
  };

  typedef struct packed {
    logic       found;
    logic [3:0] root;
    logic [4:0] quality;
    logic       slash;
  } mntc_chord_t;

  typedef struct packed {
    logic       hit;
    logic [4:0] idx;
  } mntc_tmatch_t;

  function automatic logic [3:0] pc_count(input logic [11:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < PC_COUNT; i++) begin
      n = n + {3'd0, v[i]};
    end
    return n;
  endfunction

  function automatic logic [11:0] rot12(input logic [11:0] v, input logic [3:0] by);
    logic [23:0] d;
    d = {v, v} >> by;
    return d[11:0];
  endfunction

  function automatic mntc_tmatch_t tmpl_match(input logic [11:0] v);
    mntc_tmatch_t m;
    m.hit = 1'b0;
    m.idx = '0;
    for (int t = TEMPLATE_COUNT - 1; t >= 0; t--) begin
      if (v == TEMPLATES[t]) begin
        m.hit = 1'b1;
        m.idx = 5'(t);
      end
    end
    return m;
  endfunction

endpackage

// File: design/mntc_ifs.sv
`timescale 1ns / 1ps
interface mntc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] message_kind;
  logic [4:0] midi_channel;
  logic [6:0] note_number;
  logic [6:0] velocity;
  modport source (output valid, message_kind, midi_channel, note_number, velocity,
                  input ready);
  modport sink (input valid, message_kind, midi_channel, note_number, velocity,
                output ready);
endinterface

interface mntc_out_if;
  logic       valid;
  logic       ready;
  logic       event_taken;
  logic       chord_found;
  logic [3:0] chord_root;
  logic [4:0] chord_quality;
  logic [3:0] bass_class;
  logic       is_slash;
  logic [4:0] lowest_holder;
  modport source (output valid, event_taken, chord_found, chord_root, chord_quality,
                  bass_class, is_slash, lowest_holder, input ready);
  modport sink (input valid, event_taken, chord_found, chord_root, chord_quality,
                bass_class, is_slash, lowest_holder, output ready);
endinterface

interface mntc_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] reg_index;
  logic [6:0] wr_data;
  modport source (output valid, reg_index, wr_data, input ready);
  modport sink (input valid, reg_index, wr_data, output ready);
endinterface

// File: design/mntc_mem.sv
`timescale 1ns / 1ps
module mntc_mem
  import mntc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     clr,
  input  logic                     wr_en,
  input  logic [ADDR_W-1:0]        wr_addr,
  input  logic [CHANNEL_COUNT-1:0] wr_data,
  input  logic [ADDR_W-1:0]        rd_addr,
  output logic [CHANNEL_COUNT-1:0] rd_data
);

  logic [CHANNEL_COUNT-1:0] mem [NOTE_COUNT];
  logic [NOTE_COUNT-1:0]    vld_r;
  logic [CHANNEL_COUNT-1:0] data_r;
  logic                     vld_q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    data_r <= mem[rd_addr];
  end

  // per-entry valid bits stand in for clearing the array
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      vld_q_r <= 1'b0;
    end else begin
      vld_q_r <= vld_r[rd_addr];
      if (clr) begin
        vld_r <= '0;
      end else if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = vld_q_r ? data_r : '0;

endmodule

// File: design/mntc_match.sv
`timescale 1ns / 1ps
module mntc_match
  import mntc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [11:0] pc_set,
  input  logic [3:0]  bass,
  output logic        done,
  output mntc_chord_t chord
);

  logic        busy_r;
  logic        done_r;
  logic [3:0]  step_r;
  logic [11:0] set_r;
  logic [3:0]  bass_r;
  logic        cnt_ok_r;
  mntc_chord_t chord_r;

  logic [3:0]   root;
  logic         skip;
  mntc_tmatch_t m;
  logic         fin;

  // step 0 tries the bass, steps 1..12 try roots 0..11
  always_comb begin
    root = (step_r == 4'd0) ? bass_r : step_r - 4'd1;
    skip = (step_r != 4'd0) && (root == bass_r);
    m    = tmpl_match(rot12(set_r, root));
  end

  assign fin = busy_r && (!cnt_ok_r || (!skip && m.hit) || step_r == 4'(PC_COUNT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= fin && !start;
      if (start) begin
        busy_r <= 1'b1;
      end else if (fin) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      step_r   <= '0;
      set_r    <= pc_set;
      bass_r   <= bass;
      cnt_ok_r <= pc_count(pc_set) >= 4'd3;
      chord_r  <= '0;
    end else if (busy_r) begin
      step_r <= step_r + 4'd1;
      if (cnt_ok_r && !skip && m.hit) begin
        chord_r.found   <= 1'b1;
        chord_r.root    <= root;
        chord_r.quality <= m.idx;
        chord_r.slash   <= (step_r != 4'd0);
      end
    end
  end

  assign done  = done_r;
  assign chord = chord_r;

endmodule

// File: design/midi_note_chord_tracker.sv
// each event passes the write, note scan, match and output states; an invalid channel
// goes from write straight to output. throughput: one event at a time, next input taken
// the cycle after the result is loaded. the scan reads all 128 note entries through the
// single memory read port and is followed by up to 13 rotation compares in the matcher
// reset: synchronous, active low; note map cleared at once via valid bits,
// registers return to monitor on, omni, range 0..127
`timescale 1ns / 1ps
`include "midi_note_chord_tracker_defines.svh"
module midi_note_chord_tracker
  import mntc_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  mntc_in_if.sink   in_ch,
  mntc_out_if.source out_ch,
  mntc_cfg_if.sink  cfg_ch
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WR    = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_MATCH = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  localparam logic [SCAN_W-1:0] SCAN_END = SCAN_W'(NOTE_COUNT);
  localparam logic [4:0]        CHAN_MAX = 5'(CHANNEL_COUNT);

  logic [2:0] state_r;

  // configuration
  logic       mon_en_r;
  logic [4:0] listen_r;
  logic [6:0] lo_r;
  logic [6:0] hi_r;
  logic       cfg_xfer;
  logic [4:0] listen_val;
  logic       map_clr;

  assign cfg_ch.ready = 1'b1;
  assign cfg_xfer     = cfg_ch.valid && cfg_ch.ready;
  assign listen_val   = (cfg_ch.wr_data[4:0] > 5'd16) ? 5'd0 : cfg_ch.wr_data[4:0];
  assign map_clr = cfg_xfer &&
                   ((cfg_ch.reg_index == REG_MONITOR && !cfg_ch.wr_data[0] && mon_en_r) ||
                    (cfg_ch.reg_index == REG_LISTEN && listen_val != listen_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mon_en_r <= 1'b1;
      listen_r <= '0;
      lo_r     <= '0;
      hi_r     <= 7'd127;
    end else if (cfg_xfer) begin
      case (cfg_ch.reg_index)
        REG_MONITOR: mon_en_r <= cfg_ch.wr_data[0];
        REG_LISTEN:  listen_r <= listen_val;
        REG_LOWEST:  lo_r     <= cfg_ch.wr_data;
        REG_HIGHEST: hi_r     <= cfg_ch.wr_data;
        default: ;
      endcase
    end
  end

  // input decode
  logic       in_xfer;
  logic       in_chan_ok;
  logic       in_note_ok;
  logic       in_take;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign in_chan_ok  = (in_ch.midi_channel >= 5'd1) && (in_ch.midi_channel <= CHAN_MAX);
  assign in_note_ok  = ({1'b0, in_ch.note_number} < 8'(NOTE_COUNT)) &&
                       (in_ch.note_number >= lo_r) && (in_ch.note_number <= hi_r);
  assign in_take     = mon_en_r && (in_ch.message_kind <= KIND_ON) &&
                       (listen_r == 5'd0 || in_ch.midi_channel == listen_r) &&
                       in_note_ok && in_chan_ok;

  logic       take_r;
  logic       set_on_r;
  logic       chan_ok_r;
  logic       note_in_r;
  logic [3:0] chan_idx_r;
  logic [6:0] note_r;

  // memory
  logic                     mem_wr;
  logic [ADDR_W-1:0]        mem_rd_addr;
  logic [CHANNEL_COUNT-1:0] mem_rd_data;
  logic [CHANNEL_COUNT-1:0] chan_bit;
  logic [CHANNEL_COUNT-1:0] entry_nxt;

  logic [SCAN_W-1:0] sc_r;
  logic [3:0]        pc_r;
  logic [11:0]       set_r;
  logic [11:0]       set_nxt;
  logic [3:0]        bass_r;
  logic [3:0]        bass_nxt;
  logic              have_r;
  logic              have_nxt;

  assign chan_bit  = CHANNEL_COUNT'(1) << chan_idx_r;
  assign entry_nxt = set_on_r ? (mem_rd_data | chan_bit) : (mem_rd_data & ~chan_bit);
  assign mem_wr    = (state_r == S_WR) && take_r;

  always_comb begin
    case (state_r)
      S_IDLE:  mem_rd_addr = in_ch.note_number[ADDR_W-1:0];
      S_SCAN:  mem_rd_addr = sc_r[ADDR_W-1:0];
      default: mem_rd_addr = note_r[ADDR_W-1:0];
    endcase
  end

  mntc_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (map_clr),
    .wr_en   (mem_wr),
    .wr_addr (note_r[ADDR_W-1:0]),
    .wr_data (entry_nxt),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // lowest holder of the note's entry, as updated when the event is taken
  logic [CHANNEL_COUNT-1:0] hold_ent;
  logic [4:0]               holder;

  always_comb begin
    hold_ent = take_r ? entry_nxt : mem_rd_data;
    holder   = '0;
    for (int c = CHANNEL_COUNT - 1; c >= 0; c--) begin
      if (hold_ent[c]) begin
        holder = 5'(c + 1);
      end
    end
    if (!note_in_r) begin
      holder = '0;
    end
  end

  // scan accumulation, read data is registered and lags the address
  always_comb begin
    set_nxt  = set_r;
    bass_nxt = bass_r;
    have_nxt = have_r;
    if (sc_r != '0 && mem_rd_data[chan_idx_r]) begin
      set_nxt = set_r | (12'd1 << pc_r);
      if (!have_r) begin
        bass_nxt = pc_r;
        have_nxt = 1'b1;
      end
    end
  end

  logic        mt_start;
  logic        mt_done;
  mntc_chord_t mt_chord;

  assign mt_start = (state_r == S_SCAN) && (sc_r == SCAN_END);

  mntc_match u_match (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mt_start),
    .pc_set (set_nxt),
    .bass   (bass_nxt),
    .done   (mt_done),
    .chord  (mt_chord)
  );

  logic        out_valid_r;
  logic        out_load;
  logic        taken_out_r;
  logic [4:0]  holder_r;
  mntc_chord_t chord_r;
  mntc_chord_t chord_out_r;
  logic [3:0]  bass_out_r;
  logic [4:0]  holder_out_r;

  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE:  if (in_xfer) state_r <= S_WR;
        S_WR:    state_r <= chan_ok_r ? S_SCAN : S_OUT;
        S_SCAN:  if (sc_r == SCAN_END) state_r <= S_MATCH;
        S_MATCH: if (mt_done) state_r <= S_OUT;
        S_OUT:   if (out_load) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      take_r     <= in_take;
      set_on_r   <= (in_ch.message_kind == KIND_ON) && (in_ch.velocity != 7'd0);
      chan_ok_r  <= in_chan_ok;
      note_in_r  <= ({1'b0, in_ch.note_number} < 8'(NOTE_COUNT));
      chan_idx_r <= 4'(in_ch.midi_channel - 5'd1);
      note_r     <= in_ch.note_number;
    end
    if (state_r == S_WR) begin
      holder_r <= holder;
      sc_r     <= '0;
      pc_r     <= '0;
      set_r    <= '0;
      bass_r   <= '0;
      have_r   <= 1'b0;
      chord_r  <= '0;
    end
    if (state_r == S_SCAN) begin
      sc_r   <= sc_r + SCAN_W'(1);
      set_r  <= set_nxt;
      bass_r <= bass_nxt;
      have_r <= have_nxt;
      if (sc_r != '0) begin
        pc_r <= (pc_r == 4'(PC_COUNT - 1)) ? 4'd0 : pc_r + 4'd1;
      end
    end
    if (state_r == S_MATCH && mt_done) begin
      chord_r <= mt_chord;
    end
    if (out_load) begin
      taken_out_r  <= take_r;
      chord_out_r  <= chord_r;
      bass_out_r   <= bass_r;
      holder_out_r <= holder_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.event_taken   = taken_out_r;
  assign out_ch.chord_found   = chord_out_r.found;
  assign out_ch.chord_root    = chord_out_r.root;
  assign out_ch.chord_quality = chord_out_r.quality;
  assign out_ch.bass_class    = bass_out_r;
  assign out_ch.is_slash      = chord_out_r.slash;
  assign out_ch.lowest_holder = holder_out_r;

  `MNTC_ASSERT(a_scan_range, clk, rst_n, (state_r == S_SCAN) |-> (sc_r <= SCAN_END))
  `MNTC_ASSERT(a_done_in_match, clk, rst_n, mt_done |-> (state_r == S_MATCH))
  `MNTC_ASSERT(a_no_chord_zero, clk, rst_n, (out_valid_r && !chord_out_r.found) |-> (chord_out_r.root == 4'd0 && chord_out_r.quality == 5'd0 && !chord_out_r.slash))
  `MNTC_ASSERT(a_slash_root, clk, rst_n, (out_valid_r && chord_out_r.found) |-> (chord_out_r.slash == (chord_out_r.root != bass_out_r)))
  `MNTC_ASSERT_NEVER(a_wr_outside, clk, rst_n, mem_wr && map_clr)

endmodule
